// ----- rtl/sod_pkg.sv -----
// Shared widths, opcodes and request types for the divisor-sum core.
package sod_pkg;

	localparam int VALUE_BITS = 32;
	localparam int SUM_BITS = 35;
	// The arithmetic unit covers both the value and the sum, plus one guard bit.
	localparam int ALU_W = ((VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS) + 1;
	localparam int CNT_BITS = $clog2(ALU_W + 1);
	localparam int P_BITS = (VALUE_BITS + 1) / 2 + 2;
	localparam int SQ_BITS = VALUE_BITS + 2;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic             start;
		logic             op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             done;
		logic [ALU_W-1:0] acc;
		logic [ALU_W-1:0] quo;
	} alu_rsp_t;

endpackage

// ----- rtl/sod_alu.sv -----
// Bit-serial multiply and restoring divide unit built around one shared adder.
module sod_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  sod_pkg::alu_req_t req,
	output sod_pkg::alu_rsp_t rsp
);
	import sod_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                op_q;
	logic [ALU_W-1:0]    x_q;
	logic [ALU_W-1:0]    y_q;
	logic [ALU_W-1:0]    z_q;

	logic [ALU_W-1:0] shifted;
	logic [ALU_W-1:0] add_a;
	logic [ALU_W-1:0] add_b;
	logic [ALU_W:0]   add_s;

	// Divide subtracts the divisor from the shifted remainder; multiply adds
	// the shifted multiplicand to the accumulator.
	assign shifted = {x_q[ALU_W-2:0], z_q[ALU_W-1]};
	assign add_a = (op_q == OP_DIV) ? shifted : x_q;
	assign add_b = (op_q == OP_DIV) ? ~y_q : y_q;
	assign add_s = {1'b0, add_a} + {1'b0, add_b} + {{ALU_W{1'b0}}, (op_q == OP_DIV)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(ALU_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			x_q <= '0;
			y_q <= req.b;
			z_q <= req.a;
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				// A carry out means no borrow, so the divisor fit.
				x_q <= add_s[ALU_W] ? add_s[ALU_W-1:0] : shifted;
				z_q <= {z_q[ALU_W-2:0], add_s[ALU_W]};
			end else begin
				if (z_q[0]) begin
					x_q <= add_s[ALU_W-1:0];
				end
				y_q <= {y_q[ALU_W-2:0], 1'b0};
				z_q <= {1'b0, z_q[ALU_W-1:1]};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.acc = x_q;
	assign rsp.quo = z_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("request issued while the unit is busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("completion while still stepping");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("completion without a running operation");

endmodule

// ----- rtl/sum_of_divisors_core.sv -----
// Top level of the divisor-sum core: trial-division sequencer and the shared unit.
//
// Pulse start while busy is low to hand over one value; busy then stays high until the
// answer appears on divisor_sum with done high for exactly one cycle, and the receiver
// must take it then, since it cannot stall the block. Every multiply and remainder runs
// through one serial unit ALU_W (36) bits wide. Trial divisors are 2 and then the odd
// numbers 3, 5, 7, 9, ... up to the square root of what remains, so a 32-bit prime
// takes the longest, roughly 32768 trials. Inputs 0 and 1 give 1.
module sum_of_divisors_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sod_pkg::VALUE_BITS-1:0] value,
	output logic                           done,
	output logic [sod_pkg::SUM_BITS-1:0]   divisor_sum
);
	import sod_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CHECK   = 3'd1;
	localparam logic [2:0] ST_DIV     = 3'd2;
	localparam logic [2:0] ST_MULPOW  = 3'd3;
	localparam logic [2:0] ST_MULPROD = 3'd4;
	localparam logic [2:0] ST_NEXT    = 3'd5;
	localparam logic [2:0] ST_FINAL   = 3'd6;
	localparam logic [2:0] ST_MULFIN  = 3'd7;

	logic [2:0]            state_q, state_d;
	logic                  done_q, done_d;
	alu_req_t              req_q, req_d;
	alu_rsp_t              rsp;
	logic [VALUE_BITS-1:0] rest_q, rest_d;
	logic [P_BITS-1:0]     p_q, p_d;
	logic [SQ_BITS-1:0]    psq_q, psq_d;
	logic [SUM_BITS-1:0]   product_q, product_d;
	logic [SUM_BITS-1:0]   partial_q, partial_d;
	logic [VALUE_BITS-1:0] power_q, power_d;
	logic                  strip_q, strip_d;
	logic [SUM_BITS-1:0]   sum_q, sum_d;

	sod_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	always_comb begin
		state_d = state_q;
		done_d = 1'b0;
		req_d = req_q;
		req_d.start = 1'b0;
		rest_d = rest_q;
		p_d = p_q;
		psq_d = psq_q;
		product_d = product_q;
		partial_d = partial_q;
		power_d = power_q;
		strip_d = strip_q;
		sum_d = sum_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					rest_d = value;
					p_d = P_BITS'(2);
					psq_d = SQ_BITS'(4);
					product_d = SUM_BITS'(1);
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (psq_q <= SQ_BITS'(rest_q)) begin
					req_d.start = 1'b1;
					req_d.op = OP_DIV;
					req_d.a = ALU_W'(rest_q);
					req_d.b = ALU_W'(p_q);
					power_d = VALUE_BITS'(1);
					partial_d = SUM_BITS'(1);
					strip_d = 1'b0;
					state_d = ST_DIV;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_DIV: begin
				if (rsp.done) begin
					if (rsp.acc == '0) begin
						// The divisor goes in once more: keep the quotient and raise the power.
						rest_d = rsp.quo[VALUE_BITS-1:0];
						req_d.start = 1'b1;
						req_d.op = OP_MUL;
						req_d.a = ALU_W'(power_q);
						req_d.b = ALU_W'(p_q);
						state_d = ST_MULPOW;
					end else if (strip_q) begin
						req_d.start = 1'b1;
						req_d.op = OP_MUL;
						req_d.a = ALU_W'(product_q);
						req_d.b = ALU_W'(partial_q);
						state_d = ST_MULPROD;
					end else begin
						state_d = ST_NEXT;
					end
				end
			end
			ST_MULPOW: begin
				if (rsp.done) begin
					power_d = rsp.acc[VALUE_BITS-1:0];
					partial_d = partial_q + rsp.acc[SUM_BITS-1:0];
					strip_d = 1'b1;
					req_d.start = 1'b1;
					req_d.op = OP_DIV;
					req_d.a = ALU_W'(rest_q);
					req_d.b = ALU_W'(p_q);
					state_d = ST_DIV;
				end
			end
			ST_MULPROD: begin
				if (rsp.done) begin
					product_d = rsp.acc[SUM_BITS-1:0];
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				// The square follows the divisor: (p + 2)^2 = p^2 + 4p + 4.
				if (p_q == P_BITS'(2)) begin
					p_d = P_BITS'(3);
					psq_d = SQ_BITS'(9);
				end else begin
					p_d = p_q + P_BITS'(2);
					psq_d = psq_q + SQ_BITS'({p_q, 2'b00}) + SQ_BITS'(4);
				end
				state_d = ST_CHECK;
			end
			ST_FINAL: begin
				if (rest_q > VALUE_BITS'(1)) begin
					req_d.start = 1'b1;
					req_d.op = OP_MUL;
					req_d.a = ALU_W'(product_q);
					req_d.b = ALU_W'(rest_q) + ALU_W'(1);
					state_d = ST_MULFIN;
				end else begin
					sum_d = product_q;
					done_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MULFIN: begin
				if (rsp.done) begin
					sum_d = rsp.acc[SUM_BITS-1:0];
					done_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			req_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			req_q <= req_d;
		end
	end

	always_ff @(posedge clk) begin
		rest_q <= rest_d;
		p_q <= p_d;
		psq_q <= psq_d;
		product_q <= product_d;
		partial_q <= partial_d;
		power_q <= power_d;
		strip_q <= strip_d;
		sum_q <= sum_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign divisor_sum = sum_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held for more than one cycle");
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a request in flight");
	a_sum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (divisor_sum != '0)) else $error("divisor sum of zero delivered");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the divisor-sum core, with a queue-fed driver and a result monitor.
`timescale 1ns / 100ps

module tb;
	import sod_pkg::*;

	typedef struct {
		logic [VALUE_BITS-1:0] n;
		bit                    drain;	// hold this request back until all answers are in
	} sigma_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  busy;
	logic                  done;
	logic [SUM_BITS-1:0]   divisor_sum;

	sigma_req_t          pending_q[$];
	logic [SUM_BITS-1:0] sigma_q[$];
	logic [SUM_BITS-1:0] sigma_exp;
	int                  err_count = 0;
	int                  sent_count = 0;
	int                  got_count = 0;
	int                  idle_pct;

	int unsigned small_primes [16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};

	// Corner values: zero, one, primes and prime powers, perfect numbers, all-ones and
	// alternating patterns, and highly composite numbers whose sums reach far into 35 bits.
	logic [VALUE_BITS-1:0] corner_values [$] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd28, 32'd496, 32'd8128,
		32'd65536, 32'd65537, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
		32'hAAAA_AAAA, 32'h5555_5555, 32'd3486784401, 32'd720720, 32'd735134400,
		32'd3675672000, 32'd16777213, 32'd16752649
	};

	sum_of_divisors_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.done        (done),
		.divisor_sum (divisor_sum)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sigma by trial division over 2 and the odd numbers, exact in 64 bits.
	function automatic logic [SUM_BITS-1:0] predict_sigma(logic [VALUE_BITS-1:0] n);
		longint unsigned rest, p, prod, pw, part;
		rest = n;
		p = 2;
		prod = 1;
		while (p * p <= rest) begin
			if (rest % p == 0) begin
				pw = 1;
				part = 1;
				while (rest % p == 0) begin
					pw *= p;
					part += pw;
					rest /= p;
				end
				prod *= part;
			end
			p = (p == 2) ? 3 : p + 2;
		end
		if (rest > 1)
			prod *= rest + 1;
		return prod[SUM_BITS-1:0];
	endfunction

	// Idling phases by request count: none, sender 47 %, none, sender 36 %.
	always_comb begin
		case ((sent_count / 12) % 4)
			1: idle_pct = 47;
			3: idle_pct = 36;
			default: idle_pct = 0;
		endcase
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else begin
			if (start && !busy) begin
				sigma_q = {sigma_q, predict_sigma(value)};
				sent_count++;
			end
			// A request that is still waiting on busy stays on the ports untouched.
			if (!(start && busy)) begin
				if (pending_q.size() != 0 && $urandom_range(1, 100) > idle_pct &&
						!(pending_q[0].drain && sigma_q.size() != 0)) begin
					value <= pending_q[0].n;
					start <= 1'b1;
					pending_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sigma_q.size() == 0) begin
				$error("divisor_sum: unexpected result %0d with no request outstanding",
					divisor_sum);
				err_count++;
			end else begin
				sigma_exp = sigma_q.pop_front();
				got_count++;
				if (divisor_sum !== sigma_exp) begin
					$error("divisor_sum: expected %0d, actual %0d", sigma_exp, divisor_sum);
					err_count++;
				end
			end
		end
	end

	initial begin
		sigma_req_t      r;
		longint unsigned v;
		int unsigned     k;
		int              n_random;

		foreach (corner_values[i]) begin
			r.n = corner_values[i];
			r.drain = (i == 6);
			pending_q = {pending_q, r};
		end

		// Random values are kept smooth or small so that trial division stays short.
		n_random = 78;
		for (int i = 0; i < n_random; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: v = $urandom_range(0, 65535);
				3, 4, 5: begin
					v = 1;
					repeat ($urandom_range(1, 40)) begin
						k = small_primes[$urandom_range(0, 15)];
						if (v * k <= 64'hFFFF_FFFF)
							v *= k;
					end
				end
				6, 7, 8: v = longint'($urandom_range(1, 16383)) << $urandom_range(0, 18);
				default: v = longint'($urandom_range(1, 1 << 20)) << $urandom_range(0, 11);
			endcase
			r.n = v[VALUE_BITS-1:0];
			r.drain = (i % 20 == 19);
			pending_q = {pending_q, r};
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_q.size() != 0 || start || sigma_q.size() != 0);
		repeat (100) @(posedge clk);

		$display("tb: %0d requests sent and %0d answers checked: %0d corner values, %0d random",
			sent_count, got_count, corner_values.size(), n_random);
		$display("tb: random values were small, smooth or shifted, with sender idling in phases");
		if (err_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#(120_000_000);
		$display("tb: done, errors");
		$finish;
	end

endmodule
